/* hw/rtl/fbpa_pkg.sv */
// fbpa_pkg: shared types and constants for the fixed block pool allocator
// field widths, status and opcode values, controller state and command structs
// no dependencies
package fbpa_pkg;

  localparam int SIZE_W   = 16;  // block_size register
  localparam int CNT_W    = 7;   // block_count, free count, remaining
  localparam int FIDX_W   = 6;   // request and result block index
  localparam int OFF_W    = 22;  // payload offset
  localparam int ST_W     = 2;
  localparam int STRIDE_W = 17;  // aligned stride, fits block_size plus headers
  localparam int NEFF_W   = 8;   // effective count, up to the largest pool
  localparam int CFG_IDX_W = 2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD   = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd1;

  localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST  = 16'd64;
  localparam logic [CNT_W-1:0]  BLOCK_COUNT_RST = 7'd64;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MULT,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;  // capture the request
    logic scan;  // search one chunk of marks or check a free
    logic mult;  // index times stride
    logic done;  // commit and present the result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

/* hw/rtl/fbpa_ctrl.sv */
// fbpa_ctrl: sequencing state machine for the block pool allocator
// drives the datapath through fbpa_pkg::cmd_t, reads fbpa_pkg::sts_t
// depends on fbpa_pkg
module fbpa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  fbpa_pkg::sts_t sts,
  output fbpa_pkg::cmd_t cmd
);
  import fbpa_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_next = S_MULT;
        end
      end
      S_MULT: state_next = S_DONE;
      S_DONE: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    req_stall = 1'b1;
    case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        cmd.load = req_valid;
      end
      S_SCAN: cmd.scan = 1'b1;
      S_MULT: cmd.mult = 1'b1;
      S_DONE: cmd.done = sts.out_free;
      default: ;
    endcase
  end

endmodule

/* hw/rtl/fbpa_dp.sv */
// fbpa_dp: datapath of the block pool allocator
// holds registers, used marks, free count, chunked first-free search, offset
// multiplier and result registers; depends on fbpa_pkg
module fbpa_dp #(
  parameter int MAX_BLOCKS  = 64,
  parameter int ALIGN_MASK  = 7,
  parameter int NODE_HEADER = 8,
  parameter int POOL_HEADER = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  fbpa_pkg::cmd_t                  cmd,
  output fbpa_pkg::sts_t                  sts,
  input  logic                            req_op,
  input  logic [fbpa_pkg::FIDX_W-1:0]     req_free_index,
  input  logic                            cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbpa_pkg::SIZE_W-1:0]     cfg_data,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic [fbpa_pkg::ST_W-1:0]       rsp_status,
  output logic [fbpa_pkg::FIDX_W-1:0]     rsp_block_index,
  output logic [fbpa_pkg::OFF_W-1:0]      rsp_payload_offset,
  output logic [fbpa_pkg::CNT_W-1:0]      rsp_remaining
);
  import fbpa_pkg::*;

  localparam int NCHUNK = (MAX_BLOCKS + 7) / 8;
  localparam int CK_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int IDX_W  = CK_W + 3;
  localparam int PAD    = 8 * (2 ** CK_W);
  localparam int PROD_W = IDX_W + STRIDE_W;
  localparam logic [CK_W-1:0]   LAST_CK   = CK_W'(NCHUNK - 1);
  localparam logic [NEFF_W-1:0] MAX_N     = NEFF_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0]  FREE_RST  =
      (MAX_BLOCKS < 64) ? CNT_W'(MAX_BLOCKS) : BLOCK_COUNT_RST;
  localparam logic [STRIDE_W-1:0] ALIGN_ADD = STRIDE_W'(NODE_HEADER + ALIGN_MASK);
  localparam logic [STRIDE_W-1:0] ALIGN_CLR = ~STRIDE_W'(ALIGN_MASK);
  localparam logic [OFF_W-1:0]    OFF_BASE  = OFF_W'(POOL_HEADER + NODE_HEADER);

  logic [SIZE_W-1:0]   block_size;
  logic [CNT_W-1:0]    block_count;
  logic [PAD-1:0]      marks;
  logic [CNT_W-1:0]    free_count;
  logic                op_q;
  logic [FIDX_W-1:0]   fidx_q;
  logic [CK_W-1:0]     ck;
  logic [IDX_W-1:0]    res_idx;
  logic [FIDX_W-1:0]   res_out_idx;
  logic [ST_W-1:0]     res_st;
  logic [PROD_W-1:0]   prod;

  logic [NEFF_W-1:0]   n_eff;
  logic [NEFF_W-1:0]   n_cfg;
  logic [7:0]          chunk_used;
  logic [7:0]          chunk_free;
  logic                hit;
  logic [2:0]          enc;
  logic                last;
  logic                fidx_ok;
  logic [STRIDE_W-1:0] stride;
  logic [CNT_W-1:0]    free_count_next;
  logic [PAD-1:0]      marks_next;

  assign n_eff = (NEFF_W'(block_count) > MAX_N) ? MAX_N : NEFF_W'(block_count);
  assign n_cfg = (NEFF_W'(cfg_data[CNT_W-1:0]) > MAX_N) ? MAX_N
               : NEFF_W'(cfg_data[CNT_W-1:0]);

  // one chunk of eight marks per scan cycle
  assign chunk_used = marks[{ck, 3'b000} +: 8];
  assign last = (ck == LAST_CK);

  always_comb begin
    hit = 1'b0;
    enc = '0;
    for (int j = 0; j < 8; j++) begin
      chunk_free[j] = !chunk_used[j] && (NEFF_W'({ck, 3'(j)}) < n_eff);
    end
    for (int j = 7; j >= 0; j--) begin
      if (chunk_free[j]) begin
        hit = 1'b1;
        enc = 3'(j);
      end
    end
  end

  assign fidx_ok = (NEFF_W'(fidx_q) < n_eff) && marks[IDX_W'(fidx_q)];

  assign sts.scan_done = (op_q == OP_FREE) || hit || last;
  assign sts.out_free  = !rsp_valid || !rsp_stall;

  assign stride = (STRIDE_W'(block_size) + ALIGN_ADD) & ALIGN_CLR;

  // free count and marks after the commit of the current request
  always_comb begin
    free_count_next = free_count;
    marks_next = marks;
    if (res_st == ST_OK) begin
      if (op_q == OP_ALLOC) begin
        marks_next[res_idx] = 1'b1;
        if (free_count != '0) begin
          free_count_next = free_count - CNT_W'(1);
        end
      end else begin
        marks_next[res_idx] = 1'b0;
        if (NEFF_W'(free_count) < n_eff) begin
          free_count_next = free_count + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size  <= BLOCK_SIZE_RST;
      block_count <= BLOCK_COUNT_RST;
      marks       <= '0;
      free_count  <= FREE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLOCK_SIZE: block_size <= cfg_data;
        REG_BLOCK_COUNT: begin
          block_count <= cfg_data[CNT_W-1:0];
          marks       <= '0;
          free_count  <= CNT_W'(n_cfg);
        end
        default: ;
      endcase
    end else if (cmd.done) begin
      marks      <= marks_next;
      free_count <= free_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= req_op;
      fidx_q <= req_free_index;
      ck     <= '0;
    end
    if (cmd.scan) begin
      if (op_q == OP_FREE) begin
        res_idx     <= IDX_W'(fidx_q);
        res_out_idx <= fidx_q;
        res_st      <= fidx_ok ? ST_OK : ST_BAD;
      end else if (hit) begin
        res_idx     <= {ck, enc};
        res_out_idx <= FIDX_W'({ck, enc});
        res_st      <= ST_OK;
      end else begin
        ck <= ck + CK_W'(1);
        if (last) begin
          res_idx     <= '0;
          res_out_idx <= '0;
          res_st      <= ST_EMPTY;
        end
      end
    end
    if (cmd.mult) begin
      prod <= PROD_W'(res_idx) * PROD_W'(stride);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.done) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.done) begin
      rsp_status      <= res_st;
      rsp_block_index <= res_out_idx;
      rsp_remaining   <= free_count_next;
      rsp_payload_offset <= (res_st == ST_OK) ? (OFF_W'(prod) + OFF_BASE) : '0;
    end
  end

endmodule

/* hw/rtl/fixed_block_pool_allocator.sv */
// fixed_block_pool_allocator: top level of the fixed-size block pool allocator
// ties the controller fbpa_ctrl to the datapath fbpa_dp; depends on fbpa_pkg
//
// usage:
//   request channel (req_valid / req_stall): op selects allocate or free,
//   free_index names the block to release. A transaction is taken when
//   req_valid is high and req_stall low; one request is in work at a time.
//   response channel (rsp_valid / rsp_stall): one result per request with
//   status, block_index, payload_offset and remaining.
//   configuration channel (cfg_valid / cfg_ready): cfg_index 0 writes
//   block_size, 1 writes block_count (clears all used marks); other indexes
//   do nothing. cfg_ready is always high; write only while idle.
// timing: a free passes the check, offset multiply and commit steps before
//   rsp_valid rises. An allocate scans the used marks eight per cycle, so a
//   free block that sits low is found sooner; the next request may be
//   accepted as soon as the result is presented.
// reset: every block free, block_size 64, block_count 64, no response pending.
// stall: a result waits in the output register; the next request may be
//   accepted meanwhile, but its own result waits until the first is taken.
module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS  = 64,
  parameter int ALIGN_MASK  = 7,
  parameter int NODE_HEADER = 8,
  parameter int POOL_HEADER = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic                            op,
  input  logic [fbpa_pkg::FIDX_W-1:0]     free_index,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic [fbpa_pkg::ST_W-1:0]       status,
  output logic [fbpa_pkg::FIDX_W-1:0]     block_index,
  output logic [fbpa_pkg::OFF_W-1:0]      payload_offset,
  output logic [fbpa_pkg::CNT_W-1:0]      remaining,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbpa_pkg::SIZE_W-1:0]     cfg_data
);
  import fbpa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  fbpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  fbpa_dp #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .ALIGN_MASK  (ALIGN_MASK),
    .NODE_HEADER (NODE_HEADER),
    .POOL_HEADER (POOL_HEADER)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .sts                (sts),
    .req_op             (op),
    .req_free_index     (free_index),
    .cfg_we             (cfg_valid & cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .rsp_valid          (rsp_valid),
    .rsp_stall          (rsp_stall),
    .rsp_status         (status),
    .rsp_block_index    (block_index),
    .rsp_payload_offset (payload_offset),
    .rsp_remaining      (remaining)
  );

endmodule
